### rtl/core/hrkm_pkg.sv
// Package for the HID report to key matrix core: payload types, sizes,
// and the keycode to matrix cell table. No dependencies.
package hrkm_pkg;

   localparam int KEY_SLOTS      = 6;
   localparam int MODIFIER_COUNT = 8;
   localparam int MATRIX_ROWS    = 10;
   localparam int CODE_W         = 8;
   localparam int COL_W          = 8;
   localparam int ROW_IDX_W      = 4;

   localparam logic [CODE_W-1:0]     MOD_CODE_BASE = 8'hE0;
   localparam logic [CODE_W-1:0]     CODE_EMPTY    = 8'h00;
   localparam logic [COL_W-1:0]      ROW_IDLE      = 8'hFF;

   typedef struct packed {
      logic [7:0] modifier_bits;
      logic [7:0] key_slot_0;
      logic [7:0] key_slot_1;
      logic [7:0] key_slot_2;
      logic [7:0] key_slot_3;
      logic [7:0] key_slot_4;
      logic [7:0] key_slot_5;
   } req_data_type;

   typedef struct packed {
      logic [7:0] matrix_row_0;
      logic [7:0] matrix_row_1;
      logic [7:0] matrix_row_2;
      logic [7:0] matrix_row_3;
      logic [7:0] matrix_row_4;
      logic [7:0] matrix_row_5;
      logic [7:0] matrix_row_6;
      logic [7:0] matrix_row_7;
      logic [7:0] matrix_row_8;
      logic [7:0] matrix_row_9;
   } rsp_data_type;

   typedef logic [KEY_SLOTS-1:0][CODE_W-1:0] slot_array_type;
   typedef logic [MATRIX_ROWS-1:0][COL_W-1:0] matrix_type;

   typedef struct packed {
      logic [ROW_IDX_W-1:0] row;
      logic [COL_W-1:0]     mask;
   } cell_type;

   function automatic cell_type km(input int r, input int c);
      cell_type e;
      e.row  = ROW_IDX_W'(r);
      e.mask = COL_W'(1) << c;
      return e;
   endfunction

   // Zero mask means no cell for that code.
   function automatic cell_type key_map(input logic [CODE_W-1:0] code);
      cell_type e;
      e = '0;
      case (code)
         8'h04: e = km(4, 0);  8'h05: e = km(6, 2);  8'h06: e = km(6, 1);
         8'h07: e = km(4, 1);  8'h08: e = km(2, 1);  8'h09: e = km(5, 1);
         8'h0A: e = km(4, 2);  8'h0B: e = km(5, 2);  8'h0C: e = km(3, 3);
         8'h0D: e = km(4, 3);  8'h0E: e = km(5, 3);  8'h0F: e = km(4, 4);
         8'h10: e = km(6, 3);  8'h11: e = km(7, 2);  8'h12: e = km(2, 4);
         8'h13: e = km(3, 4);  8'h14: e = km(2, 0);  8'h15: e = km(3, 1);
         8'h16: e = km(5, 0);  8'h17: e = km(2, 2);  8'h18: e = km(2, 3);
         8'h19: e = km(7, 1);  8'h1A: e = km(3, 0);  8'h1B: e = km(7, 0);
         8'h1C: e = km(3, 2);  8'h1D: e = km(6, 0);  8'h1E: e = km(0, 0);
         8'h1F: e = km(1, 0);  8'h20: e = km(0, 1);  8'h21: e = km(1, 1);
         8'h22: e = km(0, 2);  8'h23: e = km(1, 2);  8'h24: e = km(0, 3);
         8'h25: e = km(1, 3);  8'h26: e = km(0, 4);  8'h27: e = km(1, 4);
         8'h28: e = km(6, 5);  8'h29: e = km(9, 4);  8'h2A: e = km(1, 7);
         8'h2B: e = km(9, 0);  8'h2C: e = km(9, 2);  8'h2D: e = km(0, 5);
         8'h2E: e = km(9, 7);  8'h2F: e = km(9, 1);  8'h30: e = km(8, 2);
         8'h31: e = km(2, 5);  8'h32: e = km(0, 1);  8'h33: e = km(5, 4);
         8'h34: e = km(9, 4);  8'h35: e = km(8, 1);  8'h36: e = km(7, 3);
         8'h37: e = km(6, 4);  8'h38: e = km(7, 4);
         8'h4A: e = km(0, 6);  8'h4D: e = km(9, 3);  8'h4E: e = km(8, 4);
         8'h4F: e = km(0, 7);  8'h50: e = km(0, 7);  8'h51: e = km(1, 6);
         8'h52: e = km(1, 6);
         8'h54: e = km(3, 7);  8'h55: e = km(5, 7);  8'h56: e = km(8, 7);
         8'h57: e = km(7, 7);  8'h58: e = km(9, 7);  8'h59: e = km(6, 6);
         8'h5A: e = km(7, 6);  8'h5B: e = km(6, 7);  8'h5C: e = km(4, 6);
         8'h5D: e = km(5, 6);  8'h5E: e = km(4, 7);  8'h5F: e = km(2, 6);
         8'h60: e = km(3, 6);  8'h61: e = km(2, 7);  8'h62: e = km(8, 6);
         8'h63: e = km(9, 6);
         8'hE1: e = km(8, 0);  8'hE5: e = km(8, 5);
         default: e = '0;
      endcase
      return e;
   endfunction

   function automatic slot_array_type report_slots(input req_data_type d);
      slot_array_type s;
      s[0] = d.key_slot_0;
      s[1] = d.key_slot_1;
      s[2] = d.key_slot_2;
      s[3] = d.key_slot_3;
      s[4] = d.key_slot_4;
      s[5] = d.key_slot_5;
      return s;
   endfunction

   function automatic rsp_data_type pack_rows(input matrix_type m);
      rsp_data_type r;
      r.matrix_row_0 = m[0];
      r.matrix_row_1 = m[1];
      r.matrix_row_2 = m[2];
      r.matrix_row_3 = m[3];
      r.matrix_row_4 = m[4];
      r.matrix_row_5 = m[5];
      r.matrix_row_6 = m[6];
      r.matrix_row_7 = m[7];
      r.matrix_row_8 = m[8];
      r.matrix_row_9 = m[9];
      return r;
   endfunction

endpackage

### rtl/core/hrkm_update.sv
// Combinational matrix update for one report against the prior report.
// Depends on hrkm_pkg.
module hrkm_update (
   input  hrkm_pkg::req_data_type   report,
   input  logic [7:0]               prior_mods,
   input  hrkm_pkg::slot_array_type prior_slots,
   input  hrkm_pkg::matrix_type     matrix_cur,
   output hrkm_pkg::matrix_type     matrix_next
);
   import hrkm_pkg::*;

   slot_array_type now_slots;
   matrix_type     mod_set;
   matrix_type     mod_clr;
   matrix_type     rel_set;
   matrix_type     prs_clr;
   logic [KEY_SLOTS-1:0] prior_kept;
   logic [KEY_SLOTS-1:0] now_seen;

   assign now_slots = report_slots(report);

   // modifiers in bit order, last change to a cell wins
   always_comb begin
      cell_type e;
      mod_set = '0;
      mod_clr = '0;
      for (int i = 0; i < MODIFIER_COUNT; i++) begin
         e = key_map(MOD_CODE_BASE + CODE_W'(i));
         if (e.row < ROW_IDX_W'(MATRIX_ROWS)) begin
            if (report.modifier_bits[i] && !prior_mods[i]) begin
               mod_clr[e.row] = mod_clr[e.row] | e.mask;
               mod_set[e.row] = mod_set[e.row] & ~e.mask;
            end else if (!report.modifier_bits[i] && prior_mods[i]) begin
               mod_set[e.row] = mod_set[e.row] | e.mask;
               mod_clr[e.row] = mod_clr[e.row] & ~e.mask;
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
         prior_kept[i] = 1'b0;
         now_seen[i]   = 1'b0;
         for (int j = 0; j < KEY_SLOTS; j++) begin
            if (prior_slots[i] == now_slots[j]) prior_kept[i] = 1'b1;
            if (now_slots[i] == prior_slots[j]) now_seen[i]   = 1'b1;
         end
      end
   end

   always_comb begin
      cell_type er;
      cell_type ep;
      rel_set = '0;
      prs_clr = '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         er = key_map(prior_slots[i]);
         ep = key_map(now_slots[i]);
         if (prior_slots[i] != CODE_EMPTY && !prior_kept[i]
             && er.row < ROW_IDX_W'(MATRIX_ROWS)) begin
            rel_set[er.row] = rel_set[er.row] | er.mask;
         end
         if (now_slots[i] != CODE_EMPTY && !now_seen[i]
             && ep.row < ROW_IDX_W'(MATRIX_ROWS)) begin
            prs_clr[ep.row] = prs_clr[ep.row] | ep.mask;
         end
      end
   end

   always_comb begin
      for (int r = 0; r < MATRIX_ROWS; r++) begin
         matrix_next[r] = (((matrix_cur[r] & ~mod_clr[r]) | mod_set[r]) | rel_set[r])
                          & ~prs_clr[r];
      end
   end

endmodule

### rtl/core/hid_report_to_key_matrix_core.sv
// Top level: HID boot keyboard report to active-low 10x8 key matrix.
// Path: input register, then update logic into the response register.
//   Throughput: one request per cycle unless rsp_ready stalls, set by
//   the single update pass against the held matrix state.
// Reset: synchronous; clears both stages, prior report to zero, matrix to
//   all ones (no key pressed). Depends on hrkm_pkg and hrkm_update.
module hid_report_to_key_matrix_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  hrkm_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output hrkm_pkg::rsp_data_type rsp_data
);
   import hrkm_pkg::*;

   logic           in_valid_ff, in_valid_in;
   req_data_type   in_data_ff;
   logic           out_valid_ff, out_valid_in;
   rsp_data_type   rsp_data_ff;
   logic [7:0]     prior_mods_ff;
   slot_array_type prior_slots_ff;
   matrix_type     matrix_ff, matrix_in;
   logic           advance;
   logic           req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   hrkm_update u_update (
      .report      (in_data_ff),
      .prior_mods  (prior_mods_ff),
      .prior_slots (prior_slots_ff),
      .matrix_cur  (matrix_ff),
      .matrix_next (matrix_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         prior_mods_ff  <= '0;
         prior_slots_ff <= '0;
         matrix_ff      <= {MATRIX_ROWS{ROW_IDLE}};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            prior_mods_ff  <= in_data_ff.modifier_bits;
            prior_slots_ff <= report_slots(in_data_ff);
            matrix_ff      <= matrix_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= pack_rows(matrix_in);
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(matrix_ff) && $stable(prior_slots_ff))
      else $error("matrix state changed without a request advancing");

   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> rsp_data_ff == pack_rows(matrix_ff))
      else $error("response rows differ from held matrix state");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff && !rsp_ready)
      else $error("request stalled without a blocked response");

endmodule

### tb/tb_top.sv
// Testbench for hid_report_to_key_matrix_core: random and directed keyboard reports,
// checked against a matrix predictor kept in the bench. Depends on hrkm_pkg and the core.
`timescale 1ns / 100ps

module tb_top;
   import hrkm_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int RANDOM_REPORTS = 680;
   localparam logic [7:0] NO_CELL = 8'hFF;

   typedef logic [0:MATRIX_ROWS-1][COL_W-1:0] matrix_rows_type;
   typedef logic [0:KEY_SLOTS-1][CODE_W-1:0] key_list_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_data_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_data_type rsp_data;

   req_data_type pending_reports[$];
   matrix_rows_type expected_rows_q[$];

   logic [7:0] last_mods = '0;
   key_list_type last_keys = '0;
   matrix_rows_type model_rows = {MATRIX_ROWS{ROW_IDLE}};

   logic req_taken = 1'b0;
   int fail_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int idle_left = 0;
   int stall_mode = 0;
   int stall_left = 0;
   matrix_rows_type got_rows;
   matrix_rows_type want_rows;

   hid_report_to_key_matrix_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // {row, col} of the matrix cell a code drives
   function automatic logic [7:0] key_cell(input logic [7:0] code);
      logic [7:0] spot;
      case (code)
         8'h04: spot = 8'h40;  8'h05: spot = 8'h62;  8'h06: spot = 8'h61;  8'h07: spot = 8'h41;
         8'h08: spot = 8'h21;  8'h09: spot = 8'h51;  8'h0A: spot = 8'h42;  8'h0B: spot = 8'h52;
         8'h0C: spot = 8'h33;  8'h0D: spot = 8'h43;  8'h0E: spot = 8'h53;  8'h0F: spot = 8'h44;
         8'h10: spot = 8'h63;  8'h11: spot = 8'h72;  8'h12: spot = 8'h24;  8'h13: spot = 8'h34;
         8'h14: spot = 8'h20;  8'h15: spot = 8'h31;  8'h16: spot = 8'h50;  8'h17: spot = 8'h22;
         8'h18: spot = 8'h23;  8'h19: spot = 8'h71;  8'h1A: spot = 8'h30;  8'h1B: spot = 8'h70;
         8'h1C: spot = 8'h32;  8'h1D: spot = 8'h60;  8'h1E: spot = 8'h00;  8'h1F: spot = 8'h10;
         8'h20: spot = 8'h01;  8'h21: spot = 8'h11;  8'h22: spot = 8'h02;  8'h23: spot = 8'h12;
         8'h24: spot = 8'h03;  8'h25: spot = 8'h13;  8'h26: spot = 8'h04;  8'h27: spot = 8'h14;
         8'h28: spot = 8'h65;  8'h29: spot = 8'h94;  8'h2A: spot = 8'h17;  8'h2B: spot = 8'h90;
         8'h2C: spot = 8'h92;  8'h2D: spot = 8'h05;  8'h2E: spot = 8'h97;  8'h2F: spot = 8'h91;
         8'h30: spot = 8'h82;  8'h31: spot = 8'h25;  8'h32: spot = 8'h01;  8'h33: spot = 8'h54;
         8'h34: spot = 8'h94;  8'h35: spot = 8'h81;  8'h36: spot = 8'h73;  8'h37: spot = 8'h64;
         8'h38: spot = 8'h74;
         8'h4A: spot = 8'h06;  8'h4D: spot = 8'h93;  8'h4E: spot = 8'h84;  8'h4F: spot = 8'h07;
         8'h50: spot = 8'h07;  8'h51: spot = 8'h16;  8'h52: spot = 8'h16;
         8'h54: spot = 8'h37;  8'h55: spot = 8'h57;  8'h56: spot = 8'h87;  8'h57: spot = 8'h77;
         8'h58: spot = 8'h97;  8'h59: spot = 8'h66;  8'h5A: spot = 8'h76;  8'h5B: spot = 8'h67;
         8'h5C: spot = 8'h46;  8'h5D: spot = 8'h56;  8'h5E: spot = 8'h47;  8'h5F: spot = 8'h26;
         8'h60: spot = 8'h36;  8'h61: spot = 8'h27;  8'h62: spot = 8'h86;  8'h63: spot = 8'h96;
         8'hE1: spot = 8'h80;  8'hE5: spot = 8'h85;
         default: spot = NO_CELL;
      endcase
      return spot;
   endfunction

   function automatic void press_key(input logic [7:0] code, input logic down);
      logic [7:0] spot;
      spot = key_cell(code);
      if (spot != NO_CELL && spot[7:4] < MATRIX_ROWS)
         model_rows[spot[7:4]][spot[2:0]] = !down;
   endfunction

   function automatic logic holds_key(input key_list_type keys, input logic [7:0] code);
      for (int i = 0; i < KEY_SLOTS; i++)
         if (keys[i] == code)
            return 1'b1;
      return 1'b0;
   endfunction

   // modifiers, then releases, then presses
   function automatic matrix_rows_type scan_report(input req_data_type rpt);
      key_list_type now_keys;
      now_keys = {rpt.key_slot_0, rpt.key_slot_1, rpt.key_slot_2,
                  rpt.key_slot_3, rpt.key_slot_4, rpt.key_slot_5};
      for (int i = 0; i < MODIFIER_COUNT; i++)
         if (rpt.modifier_bits[i] != last_mods[i])
            press_key(MOD_CODE_BASE + i[7:0], rpt.modifier_bits[i]);
      for (int i = 0; i < KEY_SLOTS; i++)
         if (last_keys[i] != CODE_EMPTY && !holds_key(now_keys, last_keys[i]))
            press_key(last_keys[i], 1'b0);
      for (int i = 0; i < KEY_SLOTS; i++)
         if (now_keys[i] != CODE_EMPTY && !holds_key(last_keys, now_keys[i]))
            press_key(now_keys[i], 1'b1);
      last_mods = rpt.modifier_bits;
      last_keys = now_keys;
      return model_rows;
   endfunction

   task automatic add_report(input logic [7:0] mods, input logic [7:0] k0, input logic [7:0] k1,
                             input logic [7:0] k2, input logic [7:0] k3, input logic [7:0] k4,
                             input logic [7:0] k5);
      req_data_type rpt;
      rpt.modifier_bits = mods;
      rpt.key_slot_0 = k0;
      rpt.key_slot_1 = k1;
      rpt.key_slot_2 = k2;
      rpt.key_slot_3 = k3;
      rpt.key_slot_4 = k4;
      rpt.key_slot_5 = k5;
      pending_reports.push_back(rpt);
   endtask

   function automatic logic [7:0] pick_key();
      logic [7:0] code;
      case ($urandom_range(0, 9))
         0, 1, 2: code = CODE_EMPTY;
         3, 4, 5, 6, 7: code = 8'($urandom_range(8'h04, 8'h63));
         8: begin
            case ($urandom_range(0, 11))
               0: code = 8'h20;  1: code = 8'h32;  2: code = 8'h29;  3: code = 8'h34;
               4: code = 8'h4F;  5: code = 8'h50;  6: code = 8'h51;  7: code = 8'h52;
               8: code = 8'h2E;  9: code = 8'h58;  10: code = 8'hE1;
               default: code = 8'hE5;
            endcase
         end
         default: code = 8'($urandom_range(0, 255));
      endcase
      return code;
   endfunction

   initial begin
      logic [7:0] held_mods;
      key_list_type held;
      logic [63:0] raw;
      held_mods = '0;
      held = '0;

      add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      add_report(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      add_report(8'h22, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
      add_report(8'h22, 8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04);
      add_report(8'h00, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23);
      // release and press on one cell: press wins
      add_report(8'h00, 8'h32, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      add_report(8'h00, 8'h20, 8'h32, 8'h00, 8'h00, 8'h00, 8'h00);
      add_report(8'h00, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h29, 8'h34);
      // partner still held while its twin lets go
      add_report(8'h00, 8'h50, 8'h52, 8'h34, 8'h00, 8'h00, 8'h00);
      add_report(8'h00, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04);
      add_report(8'h00, 8'h04, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00);
      add_report(8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01);
      add_report(8'h00, 8'h39, 8'h3A, 8'h64, 8'hE0, 8'hE7, 8'hE8);
      add_report(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      add_report(8'h00, 8'hE1, 8'hE5, 8'h2E, 8'h58, 8'h2A, 8'h63);
      add_report(8'h22, 8'hE1, 8'hE5, 8'h2E, 8'h58, 8'h2A, 8'h63);
      add_report(8'h00, 8'hE1, 8'hE5, 8'h2E, 8'h58, 8'h2A, 8'h63);
      add_report(8'hFF, 8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFB, 8'hFA);
      add_report(8'h55, 8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04);
      add_report(8'hAA, 8'h7F, 8'hBF, 8'hDF, 8'hEF, 8'hF7, 8'hFB);
      add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

      for (int n = 0; n < RANDOM_REPORTS; n++) begin
         if ($urandom_range(0, 15) == 0) begin
            raw = {$urandom(), $urandom()};
            pending_reports.push_back(raw[55:0]);
         end else begin
            for (int i = 0; i < KEY_SLOTS; i++)
               if ($urandom_range(0, 3) == 0)
                  held[i] = pick_key();
            if ($urandom_range(0, 2) == 0)
               held_mods[$urandom_range(0, 7)] ^= 1'b1;
            if ($urandom_range(0, 31) == 0)
               held_mods = 8'($urandom());
            add_report(held_mods, held[0], held[1], held[2], held[3], held[4], held[5]);
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_reports.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_rows_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // request driver: bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (idle_left > 0) begin
            idle_left--;
            req_valid <= 1'b0;
         end else if (pending_reports.size() != 0) begin
            req_data <= pending_reports.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                        : $urandom_range(1, 12);
               idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall pattern
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 96);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (cycle_count[2:0] != 3'd0);
      endcase
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready)
         expected_rows_q.push_back(scan_report(req_data));
      if (!reset && rsp_valid && rsp_ready) begin
         got_rows = rsp_data;
         if (expected_rows_q.size() == 0) begin
            $error("matrix update with no request pending");
            fail_count++;
         end else begin
            want_rows = expected_rows_q.pop_front();
            for (int k = 0; k < MATRIX_ROWS; k++)
               if (got_rows[k] !== want_rows[k]) begin
                  $error("matrix_row_%0d: expected %h, actual %h", k, want_rows[k], got_rows[k]);
                  fail_count++;
               end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule
